// File: src/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared widths and item types for the rectangle collision resolver.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int unsigned PosW  = 16;
  localparam int unsigned SizeW = 15;
  localparam int unsigned ResW  = 17;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 96;

  typedef struct packed {
    logic signed [PosW-1:0] a_x;
    logic signed [PosW-1:0] a_y;
    logic [SizeW-1:0]       a_w;
    logic [SizeW-1:0]       a_h;
    logic signed [PosW-1:0] b_x;
    logic signed [PosW-1:0] b_y;
    logic [SizeW-1:0]       b_w;
    logic [SizeW-1:0]       b_h;
  } in_item_t;

  typedef struct packed {
    logic                   collided;
    logic signed [ResW-1:0] resolved_x;
    logic signed [ResW-1:0] resolved_y;
    logic signed [PosW-1:0] overlap_x;
    logic signed [PosW-1:0] overlap_y;
    logic [SizeW-1:0]       overlap_w;
    logic [SizeW-1:0]       overlap_h;
  } out_item_t;

endpackage

// File: src/acr_pipe.sv
// ----------------------------------------------------------------------------
// acr_pipe
// Four-stage collision datapath: edges and centers, overlap box and push
// candidates, overlap extents, axis choice and output register.
// ----------------------------------------------------------------------------
module acr_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  acr_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output acr_pkg::out_item_t out_item_o
);
  import acr_pkg::*;

  typedef struct packed {
    logic signed [PosW-1:0]  ax;
    logic signed [PosW-1:0]  ay;
    logic signed [PosW-1:0]  bx;
    logic signed [PosW-1:0]  by;
    logic [SizeW-1:0]        aw;
    logic [SizeW-1:0]        ah;
    logic signed [PosW:0]    ar;
    logic signed [PosW:0]    ab;
    logic signed [PosW:0]    br;
    logic signed [PosW:0]    bb;
    logic signed [PosW:0]    acx;
    logic signed [PosW:0]    acy;
    logic signed [PosW:0]    bcx;
    logic signed [PosW:0]    bcy;
  } s1_t;

  typedef struct packed {
    logic                    hit;
    logic signed [PosW-1:0]  ax;
    logic signed [PosW-1:0]  ay;
    logic signed [PosW-1:0]  ox;
    logic signed [PosW-1:0]  oy;
    logic signed [PosW:0]    mr;
    logic signed [PosW:0]    mb;
    logic signed [ResW-1:0]  rx_opt;
    logic signed [ResW-1:0]  ry_opt;
  } s2_t;

  typedef struct packed {
    logic                    hit;
    logic signed [PosW-1:0]  ax;
    logic signed [PosW-1:0]  ay;
    logic signed [PosW-1:0]  ox;
    logic signed [PosW-1:0]  oy;
    logic signed [PosW+1:0]  ow;
    logic signed [PosW+1:0]  oh;
    logic signed [ResW-1:0]  rx_opt;
    logic signed [ResW-1:0]  ry_opt;
  } s3_t;

  logic      v1_q, v2_q, v3_q, v4_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  s3_t       s3_d, s3_q;
  out_item_t s4_d, s4_q;

  // a stage advances when it is empty or its successor takes its contents
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: far edges and centers
  always_comb begin
    s1_d.ax  = in_item_i.a_x;
    s1_d.ay  = in_item_i.a_y;
    s1_d.bx  = in_item_i.b_x;
    s1_d.by  = in_item_i.b_y;
    s1_d.aw  = in_item_i.a_w;
    s1_d.ah  = in_item_i.a_h;
    s1_d.ar  = {in_item_i.a_x[PosW-1], in_item_i.a_x} + {2'b00, in_item_i.a_w};
    s1_d.ab  = {in_item_i.a_y[PosW-1], in_item_i.a_y} + {2'b00, in_item_i.a_h};
    s1_d.br  = {in_item_i.b_x[PosW-1], in_item_i.b_x} + {2'b00, in_item_i.b_w};
    s1_d.bb  = {in_item_i.b_y[PosW-1], in_item_i.b_y} + {2'b00, in_item_i.b_h};
    s1_d.acx = {in_item_i.a_x[PosW-1], in_item_i.a_x}
             + {3'b000, in_item_i.a_w[SizeW-1:1]};
    s1_d.acy = {in_item_i.a_y[PosW-1], in_item_i.a_y}
             + {3'b000, in_item_i.a_h[SizeW-1:1]};
    s1_d.bcx = {in_item_i.b_x[PosW-1], in_item_i.b_x}
             + {3'b000, in_item_i.b_w[SizeW-1:1]};
    s1_d.bcy = {in_item_i.b_y[PosW-1], in_item_i.b_y}
             + {3'b000, in_item_i.b_h[SizeW-1:1]};
  end

  // stage 2: hit test, overlap corners, push candidates by center order
  always_comb begin
    logic signed [PosW:0] ax_e, ay_e, bx_e, by_e;
    ax_e = {s1_q.ax[PosW-1], s1_q.ax};
    ay_e = {s1_q.ay[PosW-1], s1_q.ay};
    bx_e = {s1_q.bx[PosW-1], s1_q.bx};
    by_e = {s1_q.by[PosW-1], s1_q.by};
    s2_d.hit = !((s1_q.ar < bx_e) || (s1_q.br < ax_e) ||
                 (s1_q.ab < by_e) || (s1_q.bb < ay_e));
    s2_d.ax  = s1_q.ax;
    s2_d.ay  = s1_q.ay;
    s2_d.ox  = (s1_q.ax > s1_q.bx) ? s1_q.ax : s1_q.bx;
    s2_d.oy  = (s1_q.ay > s1_q.by) ? s1_q.ay : s1_q.by;
    s2_d.mr  = (s1_q.ar < s1_q.br) ? s1_q.ar : s1_q.br;
    s2_d.mb  = (s1_q.ab < s1_q.bb) ? s1_q.ab : s1_q.bb;
    s2_d.rx_opt = (s1_q.acx < s1_q.bcx) ? (bx_e - {2'b00, s1_q.aw}) : s1_q.br;
    s2_d.ry_opt = (s1_q.acy < s1_q.bcy) ? (by_e - {2'b00, s1_q.ah}) : s1_q.bb;
  end

  // stage 3: overlap extents
  always_comb begin
    s3_d.hit    = s2_q.hit;
    s3_d.ax     = s2_q.ax;
    s3_d.ay     = s2_q.ay;
    s3_d.ox     = s2_q.ox;
    s3_d.oy     = s2_q.oy;
    s3_d.ow     = {s2_q.mr[PosW], s2_q.mr} - {{2{s2_q.ox[PosW-1]}}, s2_q.ox};
    s3_d.oh     = {s2_q.mb[PosW], s2_q.mb} - {{2{s2_q.oy[PosW-1]}}, s2_q.oy};
    s3_d.rx_opt = s2_q.rx_opt;
    s3_d.ry_opt = s2_q.ry_opt;
  end

  // stage 4: push along the smaller extent, both on a tie; zero on a miss
  always_comb begin
    logic do_v, do_h;
    do_v = (s3_q.ow >= s3_q.oh);
    do_h = (s3_q.ow <= s3_q.oh);
    if (s3_q.hit) begin
      s4_d.collided   = 1'b1;
      s4_d.resolved_x = do_h ? s3_q.rx_opt : {s3_q.ax[PosW-1], s3_q.ax};
      s4_d.resolved_y = do_v ? s3_q.ry_opt : {s3_q.ay[PosW-1], s3_q.ay};
      s4_d.overlap_x  = s3_q.ox;
      s4_d.overlap_y  = s3_q.oy;
      s4_d.overlap_w  = s3_q.ow[SizeW-1:0];
      s4_d.overlap_h  = s3_q.oh[SizeW-1:0];
    end else begin
      s4_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = s4_q;

endmodule

// File: src/aabb_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve_top
// Rectangle overlap test with push-out of A along the axis of least overlap.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction carries one pair of rectangles (A moving,
//   B obstacle); each master-side transaction returns one result: the
//   collided flag on tuser, the pushed position of A and the overlap box on
//   tdata. All fields are zero when the rectangles neither overlap nor touch.
//   Results leave in the order the pairs arrived, one per pair.
//   Each result passes through the four register stages of the datapath
//   (edges, corners, extents, axis choice), the first of which loads at
//   the accepting edge; master tvalid rises once the last stage holds it.
//   Throughput is one pair per cycle while the receiver keeps tready high.
//   When the receiver stalls, the output stage holds its result and the
//   stages behind it keep filling; slave tready drops only once every stage
//   holds an item. Reset empties the pipeline; no state carries across
//   items.
// ----------------------------------------------------------------------------
module aabb_collision_resolve_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // a_x[15:0] a_y[31:16] a_w[46:32] a_h[61:47]
  // b_x[77:62] b_y[93:78] b_w[108:94] b_h[123:109] zero[127:124]
  input  logic [acr_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // resolved_x[16:0] resolved_y[33:17] overlap_x[49:34] overlap_y[65:50]
  // overlap_w[80:66] overlap_h[95:81]
  output logic [acr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // collided[0]
  output logic                          m_axis_tuser_o
);
  import acr_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;

  // unpack the slave-side beat
  assign in_item.a_x = s_axis_tdata_i[15:0];
  assign in_item.a_y = s_axis_tdata_i[31:16];
  assign in_item.a_w = s_axis_tdata_i[46:32];
  assign in_item.a_h = s_axis_tdata_i[61:47];
  assign in_item.b_x = s_axis_tdata_i[77:62];
  assign in_item.b_y = s_axis_tdata_i[93:78];
  assign in_item.b_w = s_axis_tdata_i[108:94];
  assign in_item.b_h = s_axis_tdata_i[123:109];

  acr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (out_item)
  );

  assign m_axis_tuser_o = out_item.collided;
  assign m_axis_tdata_o = {out_item.overlap_h, out_item.overlap_w,
                           out_item.overlap_y, out_item.overlap_x,
                           out_item.resolved_y, out_item.resolved_x};

endmodule

// File: bench/aabb_collision_resolve_top_test.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve_top_test
// Self-checking bench for the rectangle collision resolver.
// Sends directed rectangle pairs, then 1200 random ones, through the
// input stream with random idle cycles on both sides and one long receiver
// hold-off. Each result is checked field by field against a local
// prediction of the overlap box and the push-out of A.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aabb_collision_resolve_top_test;

  import acr_pkg::*;

  localparam int unsigned RandomPairs = 1200;
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned ShowLimit   = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  int unsigned pairs_total = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits = 0;
  int unsigned input_stalls = 0;
  int unsigned mismatches = 0;
  int unsigned orphans = 0;
  logic        rx_hold = 1'b0;
  logic        quiet;

  aabb_collision_resolve_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // no idling on either side for a stretch of the run
  assign quiet = (pairs_sent >= 300) && (pairs_sent < 500);

  function automatic in_item_t make_pair(int ax, int ay, int aw, int ah,
                                         int bx, int by, int bw, int bh);
    in_item_t p;
    p.a_x = ax[PosW-1:0];
    p.a_y = ay[PosW-1:0];
    p.a_w = aw[SizeW-1:0];
    p.a_h = ah[SizeW-1:0];
    p.b_x = bx[PosW-1:0];
    p.b_y = by[PosW-1:0];
    p.b_w = bw[SizeW-1:0];
    p.b_h = bh[SizeW-1:0];
    return p;
  endfunction

  function automatic logic [InDataW-1:0] pack_pair(in_item_t p);
    return {4'b0, p.b_h, p.b_w, p.b_y, p.b_x, p.a_h, p.a_w, p.a_y, p.a_x};
  endfunction

  // overlap box and push-out of A along the axis of least overlap
  function automatic out_item_t resolve_pair(in_item_t p);
    out_item_t r;
    int ax, ay, aw, ah, bx, by, bw, bh;
    int a_right, a_bottom, b_right, b_bottom;
    int ox, oy, ow, oh, rx, ry;
    ax = int'($signed(p.a_x));
    ay = int'($signed(p.a_y));
    bx = int'($signed(p.b_x));
    by = int'($signed(p.b_y));
    aw = int'(p.a_w);
    ah = int'(p.a_h);
    bw = int'(p.b_w);
    bh = int'(p.b_h);
    a_right  = ax + aw;
    a_bottom = ay + ah;
    b_right  = bx + bw;
    b_bottom = by + bh;
    r = '0;
    if (a_right < bx || b_right < ax || a_bottom < by || b_bottom < ay) begin
      return r;
    end
    ox = (ax > bx) ? ax : bx;
    oy = (ay > by) ? ay : by;
    ow = ((a_right < b_right) ? a_right : b_right) - ox;
    oh = ((a_bottom < b_bottom) ? a_bottom : b_bottom) - oy;
    rx = ax;
    ry = ay;
    if (ow >= oh) begin
      ry = (ay + (ah >>> 1) < by + (bh >>> 1)) ? by - ah : b_bottom;
    end
    if (ow <= oh) begin
      rx = (ax + (aw >>> 1) < bx + (bw >>> 1)) ? bx - aw : b_right;
    end
    r.collided   = 1'b1;
    r.resolved_x = rx[ResW-1:0];
    r.resolved_y = ry[ResW-1:0];
    r.overlap_x  = ox[PosW-1:0];
    r.overlap_y  = oy[PosW-1:0];
    r.overlap_w  = ow[SizeW-1:0];
    r.overlap_h  = oh[SizeW-1:0];
    return r;
  endfunction

  function automatic int pick_size(int unsigned style);
    case (style)
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 200);
      2: return $urandom_range(16384, 32767);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic in_item_t random_pair();
    int unsigned mode, style;
    int ax, ay, aw, ah, bx, by, bw, bh;
    mode  = $urandom_range(0, 99);
    style = $urandom_range(0, 3);
    ax = $urandom();
    ay = $urandom();
    bx = $urandom();
    by = $urandom();
    if (mode < 60) begin
      // B placed around A so that most pairs overlap or touch
      style = (style == 2) ? 2 : ($urandom_range(0, 4) == 0 ? 0 : 1);
      aw = pick_size(style);
      ah = pick_size(style);
      bw = pick_size(style);
      bh = pick_size(style);
      bx = ax + int'($urandom_range(0, aw + bw + 20)) - bw - 10;
      by = ay + int'($urandom_range(0, ah + bh + 20)) - bh - 10;
    end else if (mode < 75) begin
      aw = pick_size(3);
      ah = pick_size(3);
      bw = pick_size(3);
      bh = pick_size(3);
    end else if (mode < 90) begin
      aw = pick_size(2);
      ah = pick_size(2);
      bw = pick_size(2);
      bh = pick_size(2);
    end else begin
      aw = pick_size(1);
      ah = pick_size(1);
      bw = pick_size(1);
      bh = pick_size(1);
    end
    return make_pair(ax, ay, aw, ah, bx, by, bw, bh);
  endfunction

  // driver: hold the offered pair until the block takes it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(resolve_pair(pending_q[0]));
        if (expected_q[$].collided) begin
          hits++;
        end
        pending_q.pop_front();
        pairs_sent++;
      end else if (s_axis_tvalid_i) begin
        input_stalls++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pack_pair(pending_q[0]);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !rx_hold && (quiet || $urandom_range(0, 99) >= IdlePct);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t seen, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.collided = m_axis_tuser_o;
      {seen.overlap_h, seen.overlap_w, seen.overlap_y, seen.overlap_x,
       seen.resolved_y, seen.resolved_x} = m_axis_tdata_o;
      results_seen++;
      if (expected_q.size() == 0) begin
        orphans++;
        $display("ERROR: result with no pair pending: collided=%0b rx=%0d ry=%0d",
                 seen.collided, seen.resolved_x, seen.resolved_y);
      end else begin
        want = expected_q.pop_front();
        if (seen.collided !== want.collided || seen.resolved_x !== want.resolved_x ||
            seen.resolved_y !== want.resolved_y || seen.overlap_x !== want.overlap_x ||
            seen.overlap_y !== want.overlap_y || seen.overlap_w !== want.overlap_w ||
            seen.overlap_h !== want.overlap_h) begin
          mismatches++;
          if (mismatches <= ShowLimit) begin
            $display("ERROR: result %0d expected c=%0b r=(%0d,%0d) o=(%0d,%0d,%0d,%0d)",
                     results_seen, want.collided, want.resolved_x, want.resolved_y,
                     want.overlap_x, want.overlap_y, want.overlap_w, want.overlap_h);
            $display("       actual                c=%0b r=(%0d,%0d) o=(%0d,%0d,%0d,%0d)",
                     seen.collided, seen.resolved_x, seen.resolved_y,
                     seen.overlap_x, seen.overlap_y, seen.overlap_w, seen.overlap_h);
          end
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and back-pressures the input
  initial begin
    while (pairs_sent < 900) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    // identical boxes, misses on each axis, edge and corner touches
    pending_q.push_back(make_pair(10, 10, 20, 20, 10, 10, 20, 20));
    pending_q.push_back(make_pair(0, 0, 10, 10, 20, 0, 10, 10));
    pending_q.push_back(make_pair(0, 0, 10, 10, 0, 20, 10, 10));
    pending_q.push_back(make_pair(0, 0, 10, 10, 10, 0, 10, 10));
    pending_q.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 10));
    pending_q.push_back(make_pair(0, 0, 10, 10, 10, 10, 5, 5));
    // wide overlap pushes vertically, tall overlap pushes horizontally
    pending_q.push_back(make_pair(0, 0, 40, 10, 0, 6, 40, 10));
    pending_q.push_back(make_pair(0, 6, 40, 10, 0, 0, 40, 10));
    pending_q.push_back(make_pair(0, 0, 10, 40, 6, 0, 10, 40));
    pending_q.push_back(make_pair(6, 0, 10, 40, 0, 0, 10, 40));
    // degenerate boxes
    pending_q.push_back(make_pair(5, 5, 0, 0, 0, 0, 10, 10));
    pending_q.push_back(make_pair(3, 3, 0, 0, 3, 3, 0, 0));
    pending_q.push_back(make_pair(3, 3, 0, 0, 4, 3, 0, 0));
    // equal centers on one axis push down
    pending_q.push_back(make_pair(0, 0, 10, 4, 0, 0, 10, 5));
    // range extremes
    pending_q.push_back(make_pair(-32768, -32768, 32767, 32767,
                                  -32768, -32768, 32767, 32767));
    pending_q.push_back(make_pair(32767, 32767, 32767, 32767,
                                  -32768, -32768, 32767, 32767));
    pending_q.push_back(make_pair(-32768, -32768, 32767, 32767, -1, -1, 32767, 32767));
    pending_q.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_q.push_back(make_pair(-32768, -32768, 32767, 32767,
                                  -32767, -32768, 32767, 32767));
    pending_q.push_back(make_pair(32767, -32768, 0, 32767, 32767, 32767, 0, 0));
    repeat (RandomPairs) pending_q.push_back(random_pair());
    pairs_total = pending_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pairs_sent < pairs_total) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Checked %0d results for %0d rectangle pairs: %0d collisions, %0d misses.",
             results_seen, pairs_total, hits, pairs_total - hits);
    $display("Input held off for %0d cycles; %0d mismatches, %0d unexpected results.",
             input_stalls, mismatches, orphans);
    if (mismatches == 0 && orphans == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
